// File: rtl/aaee_pkg.sv
// shared types, codes and constants for the ascii expression evaluator
package aaee_pkg;

	localparam int MAX_MESSAGE_DEF = 256;
	localparam int WORD_W          = 32;
	localparam int STEPS           = 32;
	localparam int CNT_W           = $clog2(STEPS);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_T     = 8'h74;

	localparam logic [2:0] EXIT_FULL = 3'd5;
	localparam logic [2:0] EXIT_MISS = 3'd7;

	localparam logic [WORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] INT_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DIV0  = 2'd1,
		ST_NO_OP = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_SKIP  = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		A_IDLE,
		A_NEG_A,
		A_NEG_C,
		A_ADD,
		A_SUB,
		A_MUL,
		A_ABS_A,
		A_ABS_C,
		A_DIV,
		A_FIX_Q,
		A_DONE
	} alu_state_t;

	typedef enum logic {
		T_IDLE,
		T_CALC
	} top_state_t;

	typedef struct packed {
		logic [WORD_W-1:0] num;
		phase_t            phase;
		logic              neg;
	} parse_t;

	// parsed message handed from the parser to the arithmetic unit
	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] first_num;
		logic              first_neg;
		logic [WORD_W-1:0] second_num;
		logic              second_neg;
		logic              exit_hit;
	} msg_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		status_t           status;
	} result_t;

	function automatic logic [7:0] exit_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = CH_E;
			3'd1:    c = CH_X;
			3'd2:    c = CH_I;
			3'd3:    c = CH_T;
			3'd4:    c = CH_LF;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/ascii_arithmetic_expression_evaluator.sv
// top level of the ascii expression evaluator: stream ports, sequencing, result register
//
//  channel  direction  tdata                    tuser        tlast
//  s_axis   in         [7:0] message_byte       -            last_byte
//  m_axis   out        [31:0] result_value      [1:0] status -
//
// bytes are taken one per cycle while idle; each byte updates the parse in the cycle it is taken
// after the marked last byte the input stalls while the shared adder runs,
// and longer while a result waits on m_axis
// a message that is exactly exit and a newline gives no result and no stall
// the result register lets the next message stream in while a result waits on m_axis_tready
// arst_n clears the parser and both sequencers; no clearing pass is needed
module ascii_arithmetic_expression_evaluator #(
	parameter int MAX_MESSAGE = aaee_pkg::MAX_MESSAGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] result_value
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	aaee_pkg::top_state_t state_q, state_n;
	aaee_pkg::msg_t       msg;
	aaee_pkg::result_t    alu_res;
	logic                 take;
	logic                 start;
	logic                 alu_done;
	logic                 load;
	logic                 out_valid_q;
	logic [31:0]          out_value_q;
	aaee_pkg::status_t    out_status_q;

	assign s_axis_tready = (state_q == aaee_pkg::T_IDLE);
	assign take          = s_axis_tvalid && s_axis_tready;
	assign start         = take && s_axis_tlast && !msg.exit_hit;
	assign load          = (state_q == aaee_pkg::T_CALC) && alu_done
	                     && (!out_valid_q || m_axis_tready);

	aaee_parser #(
		.MAX_MESSAGE (MAX_MESSAGE)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.data   (s_axis_tdata),
		.last   (s_axis_tlast),
		.msg    (msg)
	);

	aaee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.msg    (msg),
		.ack    (load),
		.done   (alu_done),
		.result (alu_res)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			aaee_pkg::T_IDLE: if (start) state_n = aaee_pkg::T_CALC;
			aaee_pkg::T_CALC: if (load) state_n = aaee_pkg::T_IDLE;
			default:          state_n = aaee_pkg::T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aaee_pkg::T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q  <= alu_res.value;
			out_status_q <= alu_res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_status_q;

endmodule

// File: rtl/aaee_parser.sv
// byte parser: operator search, atoi style number parse and exit detection
module aaee_parser #(
	parameter int MAX_MESSAGE = aaee_pkg::MAX_MESSAGE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data,
	input  logic              last,
	output aaee_pkg::msg_t    msg
);

	localparam int POS_W = $clog2(MAX_MESSAGE + 1);

	logic [POS_W-1:0]  pos_q, pos_n;
	aaee_pkg::op_t     op_q, op_n;
	aaee_pkg::parse_t  first_q, first_n;
	aaee_pkg::parse_t  second_q, second_n;
	logic [2:0]        exit_q, exit_n;
	logic              ended_q, ended_n;
	aaee_pkg::op_t     code;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == aaee_pkg::CH_SPACE) || (b >= aaee_pkg::CH_TAB && b <= aaee_pkg::CH_CR);
	endfunction

	function automatic aaee_pkg::op_t op_of(input logic [7:0] b);
		aaee_pkg::op_t o;
		unique case (b)
			aaee_pkg::CH_PLUS:  o = aaee_pkg::OP_ADD;
			aaee_pkg::CH_MINUS: o = aaee_pkg::OP_SUB;
			aaee_pkg::CH_STAR:  o = aaee_pkg::OP_MUL;
			aaee_pkg::CH_SLASH: o = aaee_pkg::OP_DIV;
			default:            o = aaee_pkg::OP_NONE;
		endcase
		return o;
	endfunction

	function automatic aaee_pkg::parse_t parse_step(input aaee_pkg::parse_t p,
	                                                input logic [7:0] b);
		aaee_pkg::parse_t r;
		logic [3:0]       d;
		r = p;
		d = 4'(b - aaee_pkg::CH_ZERO);
		if (p.phase == aaee_pkg::PH_DONE) begin
			r = p;
		end else if (p.phase == aaee_pkg::PH_SKIP && is_blank(b)) begin
			r = p;
		end else if (p.phase == aaee_pkg::PH_SKIP &&
		             (b == aaee_pkg::CH_PLUS || b == aaee_pkg::CH_MINUS)) begin
			r.neg   = (b == aaee_pkg::CH_MINUS);
			r.phase = aaee_pkg::PH_SIGN;
		end else if (b >= aaee_pkg::CH_ZERO && b <= aaee_pkg::CH_NINE) begin
			// times ten plus digit, wrapping at the word width
			r.num   = {p.num[28:0], 3'b000} + {p.num[30:0], 1'b0} + {28'd0, d};
			r.phase = aaee_pkg::PH_DIGIT;
		end else begin
			r.phase = aaee_pkg::PH_DONE;
		end
		return r;
	endfunction

	assign code = op_of(data);

	always_comb begin
		pos_n    = pos_q;
		op_n     = op_q;
		first_n  = first_q;
		second_n = second_q;
		exit_n   = exit_q;
		ended_n  = ended_q;
		if (!ended_q && pos_q < POS_W'(MAX_MESSAGE)) begin
			if (data == aaee_pkg::CH_NUL) begin
				ended_n = 1'b1;
			end else begin
				if (exit_q < aaee_pkg::EXIT_FULL && data == aaee_pkg::exit_char(exit_q)) begin
					exit_n = exit_q + 3'd1;
				end else begin
					exit_n = aaee_pkg::EXIT_MISS;
				end
				// a + or - in the first byte is read as a sign; a * or / there ends the first number
				if (op_q == aaee_pkg::OP_NONE && pos_q != '0 && code != aaee_pkg::OP_NONE) begin
					op_n = code;
				end else if (op_q == aaee_pkg::OP_NONE) begin
					first_n = parse_step(first_q, data);
				end else begin
					second_n = parse_step(second_q, data);
				end
			end
			pos_n = pos_q + POS_W'(1);
		end
	end

	assign msg.op         = op_n;
	assign msg.first_num  = first_n.num;
	assign msg.first_neg  = first_n.neg;
	assign msg.second_num = second_n.num;
	assign msg.second_neg = second_n.neg;
	assign msg.exit_hit   = (exit_n == aaee_pkg::EXIT_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			op_q     <= aaee_pkg::OP_NONE;
			first_q  <= '0;
			second_q <= '0;
			exit_q   <= '0;
			ended_q  <= 1'b0;
		end else if (take) begin
			if (last) begin
				pos_q    <= '0;
				op_q     <= aaee_pkg::OP_NONE;
				first_q  <= '0;
				second_q <= '0;
				exit_q   <= '0;
				ended_q  <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				op_q     <= op_n;
				first_q  <= first_n;
				second_q <= second_n;
				exit_q   <= exit_n;
				ended_q  <= ended_n;
			end
		end
	end

endmodule

// File: rtl/aaee_alu.sv
// sequenced arithmetic around one shared 32-bit adder: negate, add, subtract, multiply, divide
module aaee_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  aaee_pkg::msg_t    msg,
	input  logic              ack,
	output logic              done,
	output aaee_pkg::result_t result
);

	aaee_pkg::alu_state_t state_q, state_n;

	logic [aaee_pkg::WORD_W-1:0] a_q, a_n;
	logic [aaee_pkg::WORD_W-1:0] c_q, c_n;
	logic [aaee_pkg::WORD_W-1:0] acc_q, acc_n;
	logic [aaee_pkg::WORD_W-1:0] aux_q, aux_n;
	logic [aaee_pkg::CNT_W-1:0]  cnt_q, cnt_n;
	aaee_pkg::op_t               op_q, op_n;
	logic                        aneg_q, aneg_n;
	logic                        cneg_q, cneg_n;
	logic                        qneg_q, qneg_n;
	aaee_pkg::result_t           res_q, res_n;

	// shared adder
	logic [aaee_pkg::WORD_W-1:0] add_x, add_y;
	logic                        add_sub;
	logic [aaee_pkg::WORD_W:0]   add_sum;

	logic [aaee_pkg::WORD_W-1:0] rem_sh;
	logic                        last_step;

	assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
	               + {{aaee_pkg::WORD_W{1'b0}}, add_sub};
	assign rem_sh    = {acc_q[aaee_pkg::WORD_W-2:0], aux_q[aaee_pkg::WORD_W-1]};
	assign last_step = (cnt_q == aaee_pkg::CNT_W'(aaee_pkg::STEPS - 1));

	always_comb begin
		state_n = state_q;
		a_n     = a_q;
		c_n     = c_q;
		acc_n   = acc_q;
		aux_n   = aux_q;
		cnt_n   = cnt_q;
		op_n    = op_q;
		aneg_n  = aneg_q;
		cneg_n  = cneg_q;
		qneg_n  = qneg_q;
		res_n   = res_q;
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			aaee_pkg::A_IDLE: begin
				if (start) begin
					a_n     = msg.first_num;
					c_n     = msg.second_num;
					aneg_n  = msg.first_neg;
					cneg_n  = msg.second_neg;
					op_n    = msg.op;
					state_n = aaee_pkg::A_NEG_A;
				end
			end
			aaee_pkg::A_NEG_A: begin
				add_y   = a_q;
				add_sub = 1'b1;
				if (aneg_q) a_n = add_sum[aaee_pkg::WORD_W-1:0];
				state_n = aaee_pkg::A_NEG_C;
			end
			aaee_pkg::A_NEG_C: begin
				add_y   = c_q;
				add_sub = 1'b1;
				if (cneg_q) c_n = add_sum[aaee_pkg::WORD_W-1:0];
				acc_n = '0;
				cnt_n = '0;
				unique case (op_q)
					aaee_pkg::OP_ADD: state_n = aaee_pkg::A_ADD;
					aaee_pkg::OP_SUB: state_n = aaee_pkg::A_SUB;
					aaee_pkg::OP_MUL: state_n = aaee_pkg::A_MUL;
					aaee_pkg::OP_DIV: begin
						// a zero divisor stays zero whatever its sign
						if (c_q == '0) begin
							res_n.value  = aaee_pkg::INT_MAX;
							res_n.status = aaee_pkg::ST_DIV0;
							state_n      = aaee_pkg::A_DONE;
						end else begin
							qneg_n  = a_q[aaee_pkg::WORD_W-1] ^ c_n[aaee_pkg::WORD_W-1];
							state_n = aaee_pkg::A_ABS_A;
						end
					end
					default: begin
						res_n.value  = aaee_pkg::INT_MIN;
						res_n.status = aaee_pkg::ST_NO_OP;
						state_n      = aaee_pkg::A_DONE;
					end
				endcase
			end
			aaee_pkg::A_ADD: begin
				add_x        = a_q;
				add_y        = c_q;
				res_n.value  = add_sum[aaee_pkg::WORD_W-1:0];
				res_n.status = aaee_pkg::ST_OK;
				state_n      = aaee_pkg::A_DONE;
			end
			aaee_pkg::A_SUB: begin
				add_x        = a_q;
				add_y        = c_q;
				add_sub      = 1'b1;
				res_n.value  = add_sum[aaee_pkg::WORD_W-1:0];
				res_n.status = aaee_pkg::ST_OK;
				state_n      = aaee_pkg::A_DONE;
			end
			aaee_pkg::A_MUL: begin
				// shift-add, low word only
				add_x = acc_q;
				add_y = a_q;
				if (c_q[0]) acc_n = add_sum[aaee_pkg::WORD_W-1:0];
				a_n   = {a_q[aaee_pkg::WORD_W-2:0], 1'b0};
				c_n   = {1'b0, c_q[aaee_pkg::WORD_W-1:1]};
				cnt_n = cnt_q + aaee_pkg::CNT_W'(1);
				if (last_step) begin
					res_n.value  = acc_n;
					res_n.status = aaee_pkg::ST_OK;
					state_n      = aaee_pkg::A_DONE;
				end
			end
			aaee_pkg::A_ABS_A: begin
				add_y   = a_q;
				add_sub = 1'b1;
				if (a_q[aaee_pkg::WORD_W-1]) a_n = add_sum[aaee_pkg::WORD_W-1:0];
				state_n = aaee_pkg::A_ABS_C;
			end
			aaee_pkg::A_ABS_C: begin
				add_y   = c_q;
				add_sub = 1'b1;
				if (c_q[aaee_pkg::WORD_W-1]) c_n = add_sum[aaee_pkg::WORD_W-1:0];
				acc_n   = '0;
				aux_n   = a_q;
				cnt_n   = '0;
				state_n = aaee_pkg::A_DIV;
			end
			aaee_pkg::A_DIV: begin
				// restoring step: carry out set means the trial subtract fits
				add_x   = rem_sh;
				add_y   = c_q;
				add_sub = 1'b1;
				acc_n   = add_sum[aaee_pkg::WORD_W] ? add_sum[aaee_pkg::WORD_W-1:0] : rem_sh;
				aux_n   = {aux_q[aaee_pkg::WORD_W-2:0], add_sum[aaee_pkg::WORD_W]};
				cnt_n   = cnt_q + aaee_pkg::CNT_W'(1);
				if (last_step) state_n = aaee_pkg::A_FIX_Q;
			end
			aaee_pkg::A_FIX_Q: begin
				add_y        = aux_q;
				add_sub      = 1'b1;
				res_n.value  = qneg_q ? add_sum[aaee_pkg::WORD_W-1:0] : aux_q;
				res_n.status = aaee_pkg::ST_OK;
				state_n      = aaee_pkg::A_DONE;
			end
			aaee_pkg::A_DONE: begin
				if (ack) state_n = aaee_pkg::A_IDLE;
			end
			default: state_n = aaee_pkg::A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aaee_pkg::A_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		a_q    <= a_n;
		c_q    <= c_n;
		acc_q  <= acc_n;
		aux_q  <= aux_n;
		cnt_q  <= cnt_n;
		op_q   <= op_n;
		aneg_q <= aneg_n;
		cneg_q <= cneg_n;
		qneg_q <= qneg_n;
		res_q  <= res_n;
	end

	assign done   = (state_q == aaee_pkg::A_DONE);
	assign result = res_q;

endmodule
